// ===== hw/rtl/spwfa_pkg.sv =====
// Package: sizes, command and status codes, and address helpers for the page walker.
`default_nettype none
package spwfa_pkg;
	localparam int FRAME_COUNT = 1024;
	localparam int FRAME_WORDS = 512;
	localparam int MEM_WORDS   = FRAME_COUNT * FRAME_WORDS;
	localparam int AW          = $clog2(MEM_WORDS);
	localparam int FB          = $clog2(FRAME_COUNT);
	localparam int FWB         = $clog2(FRAME_WORDS);
	localparam int EW          = 20;
	localparam logic [EW-1:0] ENTRY_FAULT = '1;

	typedef enum logic [1:0] {
		CMD_LOAD_SEG  = 2'd0,
		CMD_LOAD_PAGE = 2'd1,
		CMD_READ      = 2'd2,
		CMD_WRITE     = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FAULT   = 2'd1,
		ST_INVALID = 2'd2,
		ST_NOFRAME = 2'd3
	} status_t;

	// signed entry plus unsigned offset, wrapped to the memory size
	function automatic logic [AW-1:0] wrap_add(input logic [EW-1:0] e, input logic [31:0] off);
		logic signed [31:0] s;
		s = 32'(signed'(e)) + signed'(off);
		return s[AW-1:0];
	endfunction

	function automatic logic [EW-1:0] to_entry(input logic [AW-1:0] a);
		logic [31:0] w;
		w = 32'(a);
		return w[EW-1:0];
	endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/segment_page_walk_with_frame_alloc.sv =====
// Top level: two-level segment/page walker with first-fit frame allocation.
// A read hit makes two dependent lookups through one registered read port; a load seg or load
// page writes its entry and, unless the entry is the fault code, zeroes its table pair or frame.
// An allocating write scans the bitmap, zeroes each frame it takes and stores the new entry.
// One transfer in flight; the next is taken while a result waits.
// After reset a clearing pass writes zero to all MEM_WORDS (524288) words before
// the first transfer is accepted; the bitmap resets to frame 0 used at once.
`default_nettype none
module segment_page_walk_with_frame_alloc (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         cmd,
	input  wire logic [27:0]        va,
	input  wire logic [8:0]         seg,
	input  wire logic [9:0]         page,
	input  wire logic signed [19:0] frame_addr,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [1:0]              status,
	output logic [18:0]             phys_addr
);
	localparam int AW  = spwfa_pkg::AW;
	localparam int FB  = spwfa_pkg::FB;
	localparam int FWB = spwfa_pkg::FWB;
	localparam int EW  = spwfa_pkg::EW;

	// sequencer, one-hot
	typedef enum logic [10:0] {
		S_CLR  = 11'b000_0000_0001,
		S_IDLE = 11'b000_0000_0010,
		S_LD0  = 11'b000_0000_0100,
		S_RD1  = 11'b000_0000_1000,
		S_E1   = 11'b000_0001_0000,
		S_SRCH = 11'b000_0010_0000,
		S_ZERO = 11'b000_0100_0000,
		S_POST = 11'b000_1000_0000,
		S_RD2  = 11'b001_0000_0000,
		S_E2   = 11'b010_0000_0000,
		S_FIN  = 11'b100_0000_0000
	} state_t;

	// what follows the frame zeroing
	typedef enum logic [1:0] {
		PH_LOAD = 2'd0,
		PH_TBL  = 2'd1,
		PH_FRM  = 2'd2
	} phase_t;

	state_t                 state_q;
	phase_t                 ph_q;
	spwfa_pkg::cmd_t        cmd_q;
	spwfa_pkg::status_t     st_q;
	logic [27:0]            va_q;
	logic [8:0]             seg_q;
	logic [9:0]             page_q;
	logic [EW-1:0]          fa_q;
	logic [AW-1:0]          si_q, pi_q, pa_q, got_q;
	logic [AW-1:0]          clr_q;
	logic [AW-1:0]          zbase_q, zb2_q;
	logic [FWB-1:0]         zcnt_q;
	logic                   two_q;
	logic                   tbl_q;
	logic [FB-1:0]          fi_q;
	logic [(1<<FB)-1:0]     bm_q;
	logic                   out_valid_q;
	spwfa_pkg::status_t     out_st_q;
	logic [18:0]            out_pa_q;

	logic                   mem_we;
	logic [AW-1:0]          mem_waddr, mem_raddr;
	logic [EW-1:0]          mem_wdata, mem_rdata;

	logic [AW-1:0]          seg_w, vs_w, zaddr;
	logic [FB-1:0]          fi_nxt;
	logic [31:0]            vp32, vw32, pg32;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign status    = out_st_q;
	assign phys_addr = out_pa_q;

	assign seg_w  = spwfa_pkg::wrap_add('0, 32'(seg_q));
	assign vs_w   = spwfa_pkg::wrap_add('0, 32'(va_q[27:19]));
	assign vp32   = 32'(va_q[18:9]);
	assign vw32   = 32'(va_q[8:0]);
	assign pg32   = 32'(page_q);
	assign zaddr  = zbase_q + AW'(zcnt_q);
	assign fi_nxt = fi_q + FB'(1);

	spwfa_ram #(.W(EW), .D(spwfa_pkg::MEM_WORDS)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// RAM port steering
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_raddr = '0;
		unique case (state_q)
			S_CLR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			S_LD0: begin
				mem_we    = 1'b1;
				mem_waddr = seg_w;
				mem_wdata = fa_q;
			end
			S_RD1: begin
				mem_raddr = (cmd_q == spwfa_pkg::CMD_LOAD_PAGE) ? seg_w : vs_w;
			end
			S_E1: begin
				if (cmd_q == spwfa_pkg::CMD_LOAD_PAGE) begin
					mem_we    = 1'b1;
					mem_waddr = spwfa_pkg::wrap_add(mem_rdata, pg32);
					mem_wdata = fa_q;
				end
			end
			S_ZERO: begin
				mem_we    = 1'b1;
				mem_waddr = zaddr;
			end
			S_POST: begin
				if (ph_q == PH_TBL) begin
					mem_we    = 1'b1;
					mem_waddr = si_q;
					mem_wdata = spwfa_pkg::to_entry(got_q);
				end else if (ph_q == PH_FRM) begin
					mem_we    = 1'b1;
					mem_waddr = pi_q;
					mem_wdata = spwfa_pkg::to_entry(got_q);
				end
			end
			S_RD2: begin
				mem_raddr = pi_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			ph_q        <= PH_LOAD;
			cmd_q       <= spwfa_pkg::CMD_LOAD_SEG;
			st_q        <= spwfa_pkg::ST_OK;
			va_q        <= '0;
			seg_q       <= '0;
			page_q      <= '0;
			fa_q        <= '0;
			si_q        <= '0;
			pi_q        <= '0;
			pa_q        <= '0;
			got_q       <= '0;
			clr_q       <= '0;
			zbase_q     <= '0;
			zb2_q       <= '0;
			zcnt_q      <= '0;
			two_q       <= 1'b0;
			tbl_q       <= 1'b0;
			fi_q        <= '0;
			bm_q        <= (1<<FB)'(1);
			out_valid_q <= 1'b0;
			out_st_q    <= spwfa_pkg::ST_OK;
			out_pa_q    <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == '1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						cmd_q  <= spwfa_pkg::cmd_t'(cmd);
						va_q   <= va;
						seg_q  <= seg;
						page_q <= page;
						fa_q   <= frame_addr;
						st_q   <= spwfa_pkg::ST_OK;
						pa_q   <= '0;
						if (spwfa_pkg::cmd_t'(cmd) == spwfa_pkg::CMD_LOAD_SEG) begin
							state_q <= S_LD0;
						end else begin
							state_q <= S_RD1;
						end
					end
				end
				S_LD0: begin
					// segment entry written this cycle; table pair zeroed next unless the entry is the fault code
					if (fa_q != spwfa_pkg::ENTRY_FAULT) begin
						zbase_q <= spwfa_pkg::wrap_add(fa_q, 32'd0);
						zb2_q   <= spwfa_pkg::wrap_add(fa_q, 32'(spwfa_pkg::FRAME_WORDS));
						zcnt_q  <= '0;
						two_q   <= 1'b1;
						ph_q    <= PH_LOAD;
						state_q <= S_ZERO;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_RD1: begin
					si_q    <= vs_w;
					state_q <= S_E1;
				end
				S_E1: begin
					if (cmd_q == spwfa_pkg::CMD_LOAD_PAGE) begin
						if (fa_q != spwfa_pkg::ENTRY_FAULT) begin
							zbase_q <= spwfa_pkg::wrap_add(fa_q, 32'd0);
							zcnt_q  <= '0;
							two_q   <= 1'b0;
							ph_q    <= PH_LOAD;
							state_q <= S_ZERO;
						end else begin
							state_q <= S_FIN;
						end
					end else if (mem_rdata == spwfa_pkg::ENTRY_FAULT) begin
						st_q    <= spwfa_pkg::ST_FAULT;
						state_q <= S_FIN;
					end else if (mem_rdata == '0) begin
						if (cmd_q == spwfa_pkg::CMD_READ) begin
							st_q    <= spwfa_pkg::ST_INVALID;
							state_q <= S_FIN;
						end else begin
							fi_q    <= '0;
							tbl_q   <= 1'b1;
							state_q <= S_SRCH;
						end
					end else begin
						pi_q    <= spwfa_pkg::wrap_add(mem_rdata, vp32);
						state_q <= S_RD2;
					end
				end
				S_SRCH: begin
					// first fit, one frame per cycle
					if (tbl_q) begin
						if (!bm_q[fi_q] && !bm_q[fi_nxt]) begin
							got_q   <= {fi_q, FWB'(0)};
							zbase_q <= {fi_q, FWB'(0)};
							zb2_q   <= {fi_nxt, FWB'(0)};
							zcnt_q  <= '0;
							two_q   <= 1'b1;
							ph_q    <= PH_TBL;
							state_q <= S_ZERO;
						end else if (fi_q == FB'(spwfa_pkg::FRAME_COUNT - 2)) begin
							st_q    <= spwfa_pkg::ST_NOFRAME;
							state_q <= S_FIN;
						end else begin
							fi_q <= fi_nxt;
						end
					end else begin
						if (!bm_q[fi_q]) begin
							got_q   <= {fi_q, FWB'(0)};
							zbase_q <= {fi_q, FWB'(0)};
							zcnt_q  <= '0;
							two_q   <= 1'b0;
							ph_q    <= PH_FRM;
							state_q <= S_ZERO;
						end else if (fi_q == FB'(spwfa_pkg::FRAME_COUNT - 1)) begin
							st_q    <= spwfa_pkg::ST_NOFRAME;
							state_q <= S_FIN;
						end else begin
							fi_q <= fi_nxt;
						end
					end
				end
				S_ZERO: begin
					zcnt_q <= zcnt_q + FWB'(1);
					if (zcnt_q == FWB'(spwfa_pkg::FRAME_WORDS - 1)) begin
						bm_q[zbase_q[AW-1 -: FB]] <= 1'b1;
						if (two_q) begin
							two_q   <= 1'b0;
							zbase_q <= zb2_q;
						end else begin
							state_q <= S_POST;
						end
					end
				end
				S_POST: begin
					unique case (ph_q)
						PH_TBL: begin
							pi_q    <= spwfa_pkg::wrap_add(spwfa_pkg::to_entry(got_q), vp32);
							state_q <= S_RD2;
						end
						PH_FRM: begin
							pa_q    <= spwfa_pkg::wrap_add(spwfa_pkg::to_entry(got_q), vw32);
							state_q <= S_FIN;
						end
						default: begin
							state_q <= S_FIN;
						end
					endcase
				end
				S_RD2: begin
					state_q <= S_E2;
				end
				S_E2: begin
					if (mem_rdata == spwfa_pkg::ENTRY_FAULT) begin
						st_q    <= spwfa_pkg::ST_FAULT;
						state_q <= S_FIN;
					end else if (mem_rdata == '0) begin
						if (cmd_q == spwfa_pkg::CMD_READ) begin
							st_q    <= spwfa_pkg::ST_INVALID;
							state_q <= S_FIN;
						end else begin
							fi_q    <= '0;
							tbl_q   <= 1'b0;
							state_q <= S_SRCH;
						end
					end else begin
						pa_q    <= spwfa_pkg::wrap_add(mem_rdata, vw32);
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_st_q    <= st_q;
						out_pa_q    <= (st_q == spwfa_pkg::ST_OK) ? 19'(pa_q) : '0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_frame0_used: assert property (@(posedge clk) disable iff (!arst_n) bm_q[0])
		else $error("frame 0 lost its used mark");
	a_err_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != spwfa_pkg::ST_OK) |-> phys_addr == '0)
		else $error("address given with error status");
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_FIN))
		else $error("result raised outside final step");
	a_zero_writes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ZERO) |-> mem_we && (mem_wdata == '0))
		else $error("frame zeroing without a zero write");
endmodule
`default_nettype wire

// ===== hw/rtl/spwfa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module spwfa_ram #(
	parameter int W = 20,
	parameter int D = 1024
) (
	input  wire logic                 clk,
	input  wire logic                 we,
	input  wire logic [$clog2(D)-1:0] waddr,
	input  wire logic [W-1:0]         wdata,
	input  wire logic [$clog2(D)-1:0] raddr,
	output logic      [W-1:0]         rdata
);
	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== dv/segment_page_walk_with_frame_alloc_tb.sv =====
// Testbench for the segment/page walker: directed and random commands checked by a scoreboard.
`timescale 1ns / 1ps
`default_nettype none
module segment_page_walk_with_frame_alloc_tb;
	localparam int AW          = spwfa_pkg::AW;
	localparam int EW          = spwfa_pkg::EW;
	localparam int FWB         = spwfa_pkg::FWB;
	localparam int MEM_WORDS   = spwfa_pkg::MEM_WORDS;
	localparam int FRAME_COUNT = spwfa_pkg::FRAME_COUNT;
	localparam int FRAME_WORDS = spwfa_pkg::FRAME_WORDS;

	typedef struct packed {
		spwfa_pkg::status_t st;
		logic [18:0]        pa;
	} walk_result_t;

	// Scoreboard: mirrors memory and frame bitmap, predicts each result in order.
	class walk_scoreboard;
		logic [EW-1:0]     mem [0:MEM_WORDS-1];
		bit                used [0:FRAME_COUNT-1];
		walk_result_t      pending_q [$];
		int                errors;
		int                checked;
		int                cmd_seen [4];
		int                status_seen [4];

		function new();
			foreach (mem[i]) mem[i] = '0;
			foreach (used[i]) used[i] = 1'b0;
			used[0] = 1'b1;
			errors = 0;
			checked = 0;
		endfunction

		// signed entry plus index, modulo memory size
		function logic [AW-1:0] walk_addr(logic [EW-1:0] e, int unsigned idx);
			logic signed [31:0] s;
			s = {{(32-EW){e[EW-1]}}, e} + idx;
			return s[AW-1:0];
		endfunction

		function void zero_frame(logic [AW-1:0] a);
			logic [AW-1:0] k;
			for (int i = 0; i < FRAME_WORDS; i++) begin
				k = a + AW'(i);
				mem[k] = '0;
			end
			used[a[AW-1:FWB]] = 1'b1;
		endfunction

		function bit grab_table(output logic [AW-1:0] a);
			for (int i = 0; i + 1 < FRAME_COUNT; i++) begin
				if (!used[i] && !used[i+1]) begin
					a = AW'(i * FRAME_WORDS);
					zero_frame(a);
					zero_frame(AW'((i + 1) * FRAME_WORDS));
					return 1'b1;
				end
			end
			a = '0;
			return 1'b0;
		endfunction

		function bit grab_frame(output logic [AW-1:0] a);
			for (int i = 0; i < FRAME_COUNT; i++) begin
				if (!used[i]) begin
					a = AW'(i * FRAME_WORDS);
					zero_frame(a);
					return 1'b1;
				end
			end
			a = '0;
			return 1'b0;
		endfunction

		function int pending();
			return pending_q.size();
		endfunction

		// Note an accepted command: update the mirror and queue its result.
		function void note_transfer(spwfa_pkg::cmd_t c, logic [27:0] v, logic [8:0] sg,
				logic [9:0] pg, logic [EW-1:0] fa);
			walk_result_t r;
			logic [AW-1:0] si, pi, got;
			logic [EW-1:0] e1, e2;
			r.st = spwfa_pkg::ST_OK;
			r.pa = '0;
			cmd_seen[c]++;
			case (c)
				spwfa_pkg::CMD_LOAD_SEG: begin
					mem[sg] = fa;
					if (fa != spwfa_pkg::ENTRY_FAULT) begin
						zero_frame(walk_addr(fa, 0));
						zero_frame(walk_addr(fa, FRAME_WORDS));
					end
				end
				spwfa_pkg::CMD_LOAD_PAGE: begin
					pi = walk_addr(mem[sg], pg);
					mem[pi] = fa;
					if (fa != spwfa_pkg::ENTRY_FAULT)
						zero_frame(walk_addr(fa, 0));
				end
				default: begin
					si = AW'(v[27:19]);
					e1 = mem[si];
					if (e1 == spwfa_pkg::ENTRY_FAULT)
						r.st = spwfa_pkg::ST_FAULT;
					else if (e1 == '0 && c == spwfa_pkg::CMD_READ)
						r.st = spwfa_pkg::ST_INVALID;
					else begin
						if (e1 == '0) begin
							if (grab_table(got))
								mem[si] = EW'(got);
							else
								r.st = spwfa_pkg::ST_NOFRAME;
						end
						if (r.st == spwfa_pkg::ST_OK) begin
							pi = walk_addr(mem[si], v[18:9]);
							e2 = mem[pi];
							if (e2 == spwfa_pkg::ENTRY_FAULT)
								r.st = spwfa_pkg::ST_FAULT;
							else if (e2 == '0 && c == spwfa_pkg::CMD_READ)
								r.st = spwfa_pkg::ST_INVALID;
							else begin
								if (e2 == '0) begin
									if (grab_frame(got))
										mem[pi] = EW'(got);
									else
										r.st = spwfa_pkg::ST_NOFRAME;
								end
								if (r.st == spwfa_pkg::ST_OK)
									r.pa = walk_addr(mem[pi], v[8:0]);
							end
						end
					end
				end
			endcase
			pending_q.push_back(r);
		endfunction

		task report(string what);
			errors++;
			$display("%0t mismatch: %s", $realtime, what);
		endtask

		task check_result(logic [1:0] st, logic [18:0] pa);
			walk_result_t r;
			if (pending_q.size() == 0) begin
				report($sformatf("unexpected result status=%0d pa=%h", st, pa));
				return;
			end
			r = pending_q.pop_front();
			checked++;
			status_seen[r.st]++;
			if (st !== r.st)
				report($sformatf("status got %0d want %0d", st, r.st));
			if (pa !== r.pa)
				report($sformatf("phys_addr got %h want %h", pa, r.pa));
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         cmd;
	logic [27:0]        va;
	logic [8:0]         seg;
	logic [9:0]         page;
	logic signed [19:0] frame_addr;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         status;
	logic [18:0]        phys_addr;

	walk_scoreboard sb;
	int             sent;
	bit             hold_out;	// receiver long hold request

	segment_page_walk_with_frame_alloc u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.va         (va),
		.seg        (seg),
		.page       (page),
		.frame_addr (frame_addr),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.phys_addr  (phys_addr)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Offer one command at the falling edge and hold it until the transfer happens.
	// Valid stays high into the next call so bursts run back to back.
	task send_cmd(spwfa_pkg::cmd_t c, logic [27:0] v, logic [8:0] sg, logic [9:0] pg,
			logic [19:0] fa);
		@(negedge clk);
		in_valid = 1'b1;
		cmd = c;
		va = v;
		seg = sg;
		page = pg;
		frame_addr = fa;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_transfer(c, v, sg, pg, fa);
		sent++;
	endtask

	task idle_gap(int n);
		@(negedge clk);
		in_valid = 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task drain();
		idle_gap(0);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Random command. Most traffic walks a small pool of segments and pages so that
	// reads hit real mappings and allocation stays bounded; the rest is noise.
	task send_random();
		int              k;
		spwfa_pkg::cmd_t c;
		logic [27:0]     v;
		logic [19:0]     fa;
		k = $urandom_range(0, 99);
		v = {9'($urandom_range(0, 7)), 10'($urandom_range(0, 15)), 9'($urandom)};
		if ($urandom_range(0, 19) == 0)
			v[27:19] = 9'h1ff;
		if ($urandom_range(0, 19) == 0)
			v[18:9] = 10'h3ff;
		case ($urandom_range(0, 3))
			0: fa = '1;
			1: fa = 20'($urandom);
			default: fa = 20'($urandom_range(1, FRAME_COUNT - 2) * FRAME_WORDS);
		endcase
		if (k < 2)
			c = spwfa_pkg::CMD_LOAD_SEG;
		else if (k < 5)
			c = spwfa_pkg::CMD_LOAD_PAGE;
		else if (k < 15) begin
			// noise: reads anywhere, mostly empty entries
			c = spwfa_pkg::CMD_READ;
			v = 28'($urandom);
		end else if (k < 16) begin
			c = spwfa_pkg::CMD_WRITE;
			v = 28'($urandom);
		end else if (k < 55)
			c = spwfa_pkg::CMD_WRITE;
		else
			c = spwfa_pkg::CMD_READ;
		send_cmd(c, v, 9'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 7)),
			10'($urandom), fa);
	endtask

	// Receiver: random stalls while (sent / 300) is odd, else always ready; one long hold while the sender keeps offering.
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_out) begin
				out_ready = 1'b0;
				repeat (400) @(negedge clk);
				hold_out = 1'b0;
			end
			if ((sent / 300) % 2 == 0)
				out_ready = 1'b1;
			else
				out_ready = ($urandom_range(0, 3) != 0);
		end
	end

	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				sb.check_result(status, phys_addr);
		end
	end

	initial begin
		#500_000_000;
		$display("timeout: %0d results outstanding", sb.pending());
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int burst;
		sb = new();
		sent = 0;
		hold_out = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = spwfa_pkg::CMD_READ;
		va = '0;
		seg = '0;
		page = '0;
		frame_addr = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		// Directed: empty walks, allocation, faults, self-pointing and wrapping loads.
		send_cmd(spwfa_pkg::CMD_READ, 28'h0000000, '0, '0, '0);
		send_cmd(spwfa_pkg::CMD_WRITE, 28'h0000000, '0, '0, '0);
		send_cmd(spwfa_pkg::CMD_READ, 28'h00001ff, '0, '0, '0);
		send_cmd(spwfa_pkg::CMD_WRITE, 28'hfffffff, '0, '0, '0);
		send_cmd(spwfa_pkg::CMD_READ, 28'hfffffff, '0, '0, '0);
		send_cmd(spwfa_pkg::CMD_LOAD_SEG, '0, 9'd5, '0, 20'hfffff);
		send_cmd(spwfa_pkg::CMD_READ, {9'd5, 19'd3}, '0, '0, '0);
		send_cmd(spwfa_pkg::CMD_WRITE, {9'd5, 19'd3}, '0, '0, '0);
		send_cmd(spwfa_pkg::CMD_LOAD_SEG, '0, 9'd6, '0, 20'(40 * FRAME_WORDS));
		send_cmd(spwfa_pkg::CMD_LOAD_PAGE, '0, 9'd6, 10'd7, 20'hfffff);
		send_cmd(spwfa_pkg::CMD_READ, {9'd6, 10'd7, 9'd0}, '0, '0, '0);
		send_cmd(spwfa_pkg::CMD_LOAD_PAGE, '0, 9'd6, 10'h3ff, 20'(50 * FRAME_WORDS + 3));
		send_cmd(spwfa_pkg::CMD_READ, {9'd6, 10'h3ff, 9'h1ff}, '0, '0, '0);
		send_cmd(spwfa_pkg::CMD_LOAD_SEG, '0, 9'h1ff, '0, 20'h80000);	// most negative entry
		send_cmd(spwfa_pkg::CMD_READ, {9'h1ff, 10'd1, 9'd1}, '0, '0, '0);
		send_cmd(spwfa_pkg::CMD_LOAD_PAGE, '0, 9'h1ff, 10'd2, 20'hffe00);	// negative, wraps to the top frame
		send_cmd(spwfa_pkg::CMD_READ, {9'h1ff, 10'd2, 9'd9}, '0, '0, '0);
		send_cmd(spwfa_pkg::CMD_LOAD_SEG, '0, 9'd0, '0, 20'd0);	// entry points at its own frame
		send_cmd(spwfa_pkg::CMD_READ, 28'h0000000, '0, '0, '0);
		send_cmd(spwfa_pkg::CMD_WRITE, {9'd2, 10'd1, 9'd4}, '0, '0, '0);
		send_cmd(spwfa_pkg::CMD_READ, {9'd2, 10'd1, 9'd4}, '0, '0, '0);
		drain();

		// Random bursts; one long receiver hold, and a full drain after each burst that ends with sent from 1101 to 1129.
		while (sent < 1850) begin
			burst = $urandom_range(1, 24);
			repeat (burst) begin
				send_random();
				if (sent == 600)
					hold_out = 1'b1;
			end
			if (sent > 1100 && sent < 1130)
				drain();
			else if ($urandom_range(0, 3) != 0)
				idle_gap($urandom_range(1, 12));
		end
		drain();
		repeat (50) @(posedge clk);

		$display("covered %0d commands: loads seg %0d, loads page %0d, reads %0d, writes %0d",
			sent, sb.cmd_seen[spwfa_pkg::CMD_LOAD_SEG], sb.cmd_seen[spwfa_pkg::CMD_LOAD_PAGE],
			sb.cmd_seen[spwfa_pkg::CMD_READ], sb.cmd_seen[spwfa_pkg::CMD_WRITE]);
		$display("results ok %0d, fault %0d, invalid %0d, no frame %0d; %0d mismatches",
			sb.status_seen[spwfa_pkg::ST_OK], sb.status_seen[spwfa_pkg::ST_FAULT],
			sb.status_seen[spwfa_pkg::ST_INVALID], sb.status_seen[spwfa_pkg::ST_NOFRAME],
			sb.errors);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
`default_nettype wire

// ===== files.f =====
hw/rtl/spwfa_pkg.sv
hw/rtl/spwfa_ram.sv
hw/rtl/segment_page_walk_with_frame_alloc.sv
dv/segment_page_walk_with_frame_alloc_tb.sv
